[rtl/i2cbb_pkg.sv]
// ----------------------------------------------------------------------------
// I2C bit-level sequencer package
// Command codes, the one-hot operation type and the per-tick result record
// shared by the sequencer core and the top level.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int BIT_W   = 4;
	localparam int SUB_W   = 2;
	localparam int TDATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INIT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ACK   = 3'd6;

	localparam logic [BYTE_W-1:0] ACK_LIMIT_RESET = 8'd250;
	localparam logic [BYTE_W-1:0] POLL_MAX        = 8'd255;
	localparam logic [BIT_W-1:0]  BITS_PER_BYTE   = 4'd8;

	typedef enum logic [6:0] {
		OP_IDLE  = 7'b0000001,
		OP_INIT  = 7'b0000010,
		OP_START = 7'b0000100,
		OP_STOP  = 7'b0001000,
		OP_WRITE = 7'b0010000,
		OP_READ  = 7'b0100000,
		OP_ACK   = 7'b1000000
	} op_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rd_data;
		logic              ack_ok;
	} res_t;

	function automatic op_t cmd_to_op(input logic [CMD_W-1:0] cmd);
		op_t op;
		unique case (cmd)
			CMD_INIT:  op = OP_INIT;
			CMD_START: op = OP_START;
			CMD_STOP:  op = OP_STOP;
			CMD_WRITE: op = OP_WRITE;
			CMD_READ:  op = OP_READ;
			CMD_ACK:   op = OP_ACK;
			default:   op = OP_IDLE;
		endcase
		return op;
	endfunction

endpackage

[rtl/i2cbb_core.sv]
// ----------------------------------------------------------------------------
// I2C bit-level sequencer core
// Holds the sequencer state and performs one pin step per enabled tick,
// producing the result of that tick combinationally.
// ----------------------------------------------------------------------------
module i2cbb_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [i2cbb_pkg::CMD_W-1:0]   cmd,
	input  logic [i2cbb_pkg::BYTE_W-1:0]  wr_data,
	input  logic                          sda_in,
	input  logic [i2cbb_pkg::BYTE_W-1:0]  ack_poll_limit,
	output i2cbb_pkg::res_t               res
);
	import i2cbb_pkg::*;

	op_t               op_q, op_n;
	logic [BIT_W-1:0]  bit_q, bit_n;
	logic [SUB_W-1:0]  sub_q, sub_n;
	logic [BYTE_W-1:0] shift_q, shift_n;
	logic [BYTE_W-1:0] poll_q, poll_n;
	logic              scl_q, scl_n;
	logic              sda_q, sda_n;
	logic [BYTE_W-1:0] rd_q, rd_n;
	logic              ack_q, ack_n;
	logic              done;

	always_comb begin
		op_n    = op_q;
		bit_n   = bit_q;
		sub_n   = sub_q;
		shift_n = shift_q;
		poll_n  = poll_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rd_n    = rd_q;
		ack_n   = ack_q;
		done    = 1'b0;

		if (op_q == OP_IDLE && cmd_to_op(cmd) != OP_IDLE) begin
			op_n    = cmd_to_op(cmd);
			bit_n   = '0;
			sub_n   = '0;
			poll_n  = '0;
			shift_n = (cmd == CMD_WRITE) ? wr_data : '0;
		end

		unique case (op_n)
			OP_IDLE: begin
			end
			OP_INIT: begin
				if (sub_n == 2'd0) begin
					scl_n = 1'b1;
					sub_n = 2'd1;
				end else begin
					sda_n = 1'b1;
					done  = 1'b1;
				end
			end
			OP_START, OP_STOP: begin
				if (sub_n == 2'd0) begin
					sda_n = (op_n == OP_START);
					sub_n = 2'd1;
				end else if (sub_n == 2'd1) begin
					scl_n = 1'b1;
					sub_n = 2'd2;
				end else begin
					sda_n = (op_n == OP_STOP);
					done  = 1'b1;
				end
			end
			OP_WRITE: begin
				if (!bit_n[BIT_W-1]) begin
					if (sub_n == 2'd0) begin
						scl_n = 1'b0;
						sub_n = 2'd1;
					end else if (sub_n == 2'd1) begin
						sda_n   = shift_n[BYTE_W-1];
						shift_n = {shift_n[BYTE_W-2:0], 1'b0};
						sub_n   = 2'd2;
					end else begin
						scl_n = 1'b1;
						sub_n = 2'd0;
						bit_n = bit_n + 1'b1;
					end
				end else if (sub_n == 2'd0) begin
					scl_n = 1'b0;
					sub_n = 2'd1;
				end else begin
					sda_n = 1'b1;
					done  = 1'b1;
				end
			end
			OP_READ: begin
				if (sub_n == 2'd0) begin
					scl_n = 1'b0;
					sub_n = 2'd1;
				end else if (sub_n == 2'd1) begin
					sda_n = 1'b1;
					sub_n = 2'd2;
				end else if (sub_n == 2'd2) begin
					scl_n = 1'b1;
					sub_n = 2'd3;
				end else begin
					shift_n = {shift_n[BYTE_W-2:0], sda_in};
					scl_n   = 1'b0;
					bit_n   = bit_n + 1'b1;
					if (bit_n >= BITS_PER_BYTE) begin
						rd_n = shift_n;
						done = 1'b1;
					end else begin
						sub_n = 2'd2;
					end
				end
			end
			OP_ACK: begin
				if (sub_n == 2'd0) begin
					scl_n = 1'b1;
					sub_n = 2'd1;
				end else if (!sda_in) begin
					ack_n = 1'b1;
					scl_n = 1'b0;
					done  = 1'b1;
				end else begin
					if (poll_n != POLL_MAX) begin
						poll_n = poll_n + 1'b1;
					end
					if (poll_n >= ack_poll_limit) begin
						ack_n = 1'b0;
						scl_n = 1'b0;
						done  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (done) begin
			op_n  = OP_IDLE;
			sub_n = '0;
			bit_n = '0;
		end

		res.scl     = scl_n;
		res.sda     = sda_n;
		res.busy    = (op_n != OP_IDLE);
		res.done    = done;
		res.rd_data = rd_n;
		res.ack_ok  = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			bit_q   <= '0;
			sub_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rd_q    <= '0;
			ack_q   <= 1'b0;
		end else if (step_en) begin
			op_q    <= op_n;
			bit_q   <= bit_n;
			sub_q   <= sub_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rd_q    <= rd_n;
			ack_q   <= ack_n;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.done |-> !res.busy)
		else $error("Command finished but sequencer still reports busy.");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("Bit counter ran past one byte.");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && op_q == OP_IDLE && cmd == CMD_TICK |=>
		scl_q == $past(scl_q) && sda_q == $past(sda_q))
		else $error("Pins moved on an idle tick without a command.");

endmodule

[rtl/i2c_bitbang_master_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master sequencer
// Each request is one bus tick; the block sequences SCL and SDA for init,
// start, stop, byte write, byte read and acknowledge wait commands.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle whenever the output side takes results,
// and each produces exactly one result request. A request is registered,
// then the sequencer state is advanced by a single pass of next-state logic
// and the result is registered, so a result passes the input register and
// the result register on its way to the output.
// A command is picked up only when the sequencer is idle; the tick that
// carries it performs its first pin step, and commands arriving while busy are
// ignored. The acknowledge poll limit may be written only while no request is
// in flight; a write in the middle of a command applies from the next poll,
// and a value of zero behaves as one.
module i2c_bitbang_master_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [i2cbb_pkg::BYTE_W-1:0]     cfg_wr_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [2:0] cmd, [10:3] wr_data, [11] sda_in, [15:12] zero
	input  logic [i2cbb_pkg::TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] scl_out, [1] sda_out, [2] busy_res, [10:3] rd_data, [11] ack_ok,
	// [15:12] zero
	output logic [i2cbb_pkg::TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast
);
	import i2cbb_pkg::*;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] wr_data_s1;
	logic              sda_in_s1;
	logic              out_valid_q;
	res_t              out_q;
	res_t              res;
	logic [BYTE_W-1:0] limit_q;
	logic              step_en;
	logic              in_take;

	assign step_en  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step_en;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ACK_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1     <= s_tdata[CMD_W-1:0];
			wr_data_s1 <= s_tdata[CMD_W+BYTE_W-1:CMD_W];
			sda_in_s1  <= s_tdata[CMD_W+BYTE_W];
		end
	end

	i2cbb_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (step_en),
		.cmd            (cmd_s1),
		.wr_data        (wr_data_s1),
		.sda_in         (sda_in_s1),
		.ack_poll_limit (limit_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.done;
	assign m_tdata  = {4'b0000, out_q.ack_ok, out_q.rd_data, out_q.busy, out_q.sda,
		out_q.scl};

	a_hold_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step_en |=> valid_s1)
		else $error("A stalled request was dropped.");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> m_tvalid)
		else $error("A processed request produced no result.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !step_en)
		else $error("A pending result was overwritten.");

endmodule

[test/tb_i2c_bitbang_master_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master sequencer testbench
// Drives bus-tick requests through the input stream. Each tick is a command
// or a plain tick. The testbench predicts SCL, SDA, busy, done, the read byte
// and the acknowledge flag for every tick, and checks each result against the
// prediction. Directed sequences come first, then random command sequences
// under eight poll limits, all but one with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_i2c_bitbang_master_sequencer;
	import i2cbb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0]   cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;

	i2c_bitbang_master_sequencer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sequencer state as predicted from the accepted ticks.
	op_t                cur_op = OP_IDLE;
	logic [BIT_W-1:0]   bit_no = '0;
	logic [SUB_W-1:0]   step_no = '0;
	logic [BYTE_W-1:0]  shreg = '0;
	logic [BYTE_W-1:0]  polls = '0;
	logic               scl_lv = 1'b1;
	logic               sda_lv = 1'b1;
	logic [BYTE_W-1:0]  rd_byte = '0;
	logic               ack_lv = 1'b0;
	logic [BYTE_W-1:0]  poll_limit = ACK_LIMIT_RESET;

	logic [TDATA_W-1:0] tick_q[$];
	res_t               bus_state_q[$];
	res_t               head;

	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	int n_pushed = 0;
	int n_taken = 0;
	int n_checked = 0;
	int errors = 0;
	int n_cmds = 0;
	int n_acked = 0;
	int n_timeouts = 0;
	int n_reads = 0;

	task automatic i2c_tick(input logic [TDATA_W-1:0] req);
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] wbyte;
		logic              sda_s;
		logic              done;
		res_t              r;
		cmd = req[2:0];
		wbyte = req[10:3];
		sda_s = req[11];
		done = 1'b0;
		if (cur_op == OP_IDLE && cmd >= CMD_INIT && cmd <= CMD_ACK) begin
			case (cmd)
				CMD_INIT: cur_op = OP_INIT;
				CMD_START: cur_op = OP_START;
				CMD_STOP: cur_op = OP_STOP;
				CMD_WRITE: cur_op = OP_WRITE;
				CMD_READ: cur_op = OP_READ;
				default: cur_op = OP_ACK;
			endcase
			bit_no = '0;
			step_no = '0;
			polls = '0;
			shreg = (cmd == CMD_WRITE) ? wbyte : '0;
			n_cmds++;
		end
		case (cur_op)
			OP_INIT: begin
				if (step_no == 2'd0) begin
					scl_lv = 1'b1;
					step_no = 2'd1;
				end else begin
					sda_lv = 1'b1;
					done = 1'b1;
				end
			end
			OP_START, OP_STOP: begin
				if (step_no == 2'd0) begin
					sda_lv = (cur_op == OP_START);
					step_no = 2'd1;
				end else if (step_no == 2'd1) begin
					scl_lv = 1'b1;
					step_no = 2'd2;
				end else begin
					sda_lv = (cur_op == OP_STOP);
					done = 1'b1;
				end
			end
			OP_WRITE: begin
				if (bit_no < BITS_PER_BYTE) begin
					case (step_no)
						2'd0: begin
							scl_lv = 1'b0;
							step_no = 2'd1;
						end
						2'd1: begin
							sda_lv = shreg[7];
							shreg = shreg << 1;
							step_no = 2'd2;
						end
						default: begin
							scl_lv = 1'b1;
							step_no = 2'd0;
							bit_no = bit_no + 1'b1;
						end
					endcase
				end else if (step_no == 2'd0) begin
					scl_lv = 1'b0;
					step_no = 2'd1;
				end else begin
					sda_lv = 1'b1;
					done = 1'b1;
				end
			end
			OP_READ: begin
				case (step_no)
					2'd0: begin
						scl_lv = 1'b0;
						step_no = 2'd1;
					end
					2'd1: begin
						sda_lv = 1'b1;
						step_no = 2'd2;
					end
					2'd2: begin
						scl_lv = 1'b1;
						step_no = 2'd3;
					end
					default: begin
						shreg = {shreg[BYTE_W-2:0], sda_s};
						scl_lv = 1'b0;
						bit_no = bit_no + 1'b1;
						if (bit_no >= BITS_PER_BYTE) begin
							rd_byte = shreg;
							done = 1'b1;
							n_reads++;
						end else begin
							step_no = 2'd2;
						end
					end
				endcase
			end
			OP_ACK: begin
				if (step_no == 2'd0) begin
					scl_lv = 1'b1;
					step_no = 2'd1;
				end else if (!sda_s) begin
					ack_lv = 1'b1;
					scl_lv = 1'b0;
					done = 1'b1;
					n_acked++;
				end else begin
					if (polls < POLL_MAX)
						polls = polls + 1'b1;
					if (polls >= poll_limit) begin
						ack_lv = 1'b0;
						scl_lv = 1'b0;
						done = 1'b1;
						n_timeouts++;
					end
				end
			end
			default: ;
		endcase
		if (done) begin
			cur_op = OP_IDLE;
			step_no = '0;
			bit_no = '0;
		end
		r.scl = scl_lv;
		r.sda = sda_lv;
		r.busy = (cur_op != OP_IDLE);
		r.done = done;
		r.rd_data = rd_byte;
		r.ack_ok = ack_lv;
		bus_state_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				i2c_tick(s_tdata);
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && !(src_gaps && $urandom_range(99) < 35)) begin
					s_tvalid <= 1'b1;
					s_tdata <= tick_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			errors++;
			if (errors < 40)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bus_state_q.size() == 0) begin
					errors++;
					if (errors < 40)
						$display("%0t: unexpected result, expected none, got %h last %b",
							$time, m_tdata, m_tlast);
				end else begin
					head = bus_state_q.pop_front();
					check_field("scl_out", 8'(head.scl), 8'(m_tdata[0]));
					check_field("sda_out", 8'(head.sda), 8'(m_tdata[1]));
					check_field("busy_res", 8'(head.busy), 8'(m_tdata[2]));
					check_field("cmd_done", 8'(head.done), 8'(m_tlast));
					check_field("rd_data", head.rd_data, m_tdata[10:3]);
					check_field("ack_ok", 8'(head.ack_ok), 8'(m_tdata[11]));
					n_checked++;
				end
			end
			m_tready <= !(sink_gaps && $urandom_range(99) < 35);
		end
	end

	task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
			input logic sda_s);
		tick_q.push_back({4'b0, sda_s, wbyte, cmd});
		n_pushed++;
	endtask

	// Sends a command and the ticks that carry it to completion. For an
	// acknowledge wait, the given number of polls see SDA high before it
	// drops. A ragged sequence is cut short or padded and carries stray
	// commands inside the busy window.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
			input int ones, input bit ragged, input int sda_fix);
		int   span;
		logic s;
		logic [CMD_W-1:0] c;
		case (cmd)
			CMD_INIT: span = 1;
			CMD_START, CMD_STOP: span = 2;
			CMD_WRITE: span = 25;
			CMD_READ: span = 17;
			CMD_ACK: span = ones + 1;
			default: span = 0;
		endcase
		if (ragged && $urandom_range(1))
			span = span - $urandom_range(0, span);
		push_req(cmd, wbyte, 1'($urandom_range(1)));
		for (int i = 0; i < span; i++) begin
			if (cmd == CMD_ACK)
				s = (i < ones);
			else if (sda_fix > 1)
				s = 1'($urandom_range(1));
			else
				s = sda_fix[0];
			c = (ragged && $urandom_range(99) < 30) ? 3'($urandom_range(7)) : CMD_TICK;
			push_req(c, 8'($urandom_range(255)), s);
		end
		for (int i = $urandom_range(0, ragged ? 3 : 1); i > 0; i--)
			push_req($urandom_range(1) ? CMD_TICK : CMD_NONE, 8'($urandom_range(255)),
				1'($urandom_range(1)));
	endtask

	task automatic wait_drain();
		while (n_taken != n_pushed || n_checked != n_taken)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drain();
		while (cur_op != OP_IDLE) begin
			push_req(CMD_TICK, 8'h00, 1'b0);
			wait_drain();
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int               mark;
		int               lim_eff;
		int               ones;
		logic [CMD_W-1:0] c;
		logic [BYTE_W-1:0] lim_next;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_req(CMD_TICK, 8'h00, 1'b0);
		push_req(CMD_NONE, 8'hFF, 1'b1);
		send_cmd(CMD_INIT, 8'h00, 0, 1'b0, 2);
		send_cmd(CMD_START, 8'h00, 0, 1'b0, 2);
		send_cmd(CMD_WRITE, 8'hFF, 0, 1'b0, 2);
		send_cmd(CMD_WRITE, 8'h00, 0, 1'b0, 2);
		send_cmd(CMD_ACK, 8'h00, 0, 1'b0, 2);
		send_cmd(CMD_WRITE, 8'hA5, 0, 1'b0, 2);
		send_cmd(CMD_ACK, 8'h00, 3, 1'b0, 2);
		send_cmd(CMD_READ, 8'h00, 0, 1'b0, 1);
		send_cmd(CMD_READ, 8'hFF, 0, 1'b0, 0);
		send_cmd(CMD_READ, 8'h00, 0, 1'b0, 2);
		send_cmd(CMD_ACK, 8'h00, 251, 1'b0, 2);
		push_req(CMD_STOP, 8'h5A, 1'b1);
		push_req(CMD_READ, 8'hC3, 1'b0);
		push_req(CMD_TICK, 8'h00, 1'b1);
		push_req(CMD_TICK, 8'h00, 1'b0);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: lim_next = 8'd1;
				1: lim_next = 8'd0;
				2: lim_next = 8'd255;
				3: lim_next = 8'd2;
				default: lim_next = 8'($urandom_range(3, 40));
			endcase
			settle();
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= lim_next;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			poll_limit = lim_next;
			lim_eff = (lim_next == 8'd0) ? 1 : int'(lim_next);
			src_gaps = (p != 4);
			sink_gaps = (p != 4);
			mark = n_pushed;
			while (n_pushed - mark < 160) begin
				c = ($urandom_range(99) < 10) ? 3'($urandom_range(7))
					: 3'($urandom_range(1, 6));
				ones = ($urandom_range(99) < 85) ? $urandom_range(0, 5)
					: $urandom_range(0, lim_eff + 1);
				send_cmd(c, 8'($urandom_range(255)), ones, $urandom_range(99) < 20, 2);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (bus_state_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, bus_state_q.size());
		end
		$display("Covered %0d bus ticks with %0d checked results over eight poll limits.",
			n_taken, n_checked);
		$display("Commands started: %0d, reads: %0d, acks seen: %0d, ack timeouts: %0d.",
			n_cmds, n_reads, n_acked, n_timeouts);
		if (errors == 0)
			$display("i2c_bitbang_master_sequencer regression: pass");
		else
			$display("i2c_bitbang_master_sequencer regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out with %0d requests pending.", bus_state_q.size());
		$display("i2c_bitbang_master_sequencer regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/i2cbb_pkg.sv
rtl/i2cbb_core.sv
rtl/i2c_bitbang_master_sequencer.sv
test/tb_i2c_bitbang_master_sequencer.sv
